// ===== design/pca_pkg.sv =====
// pca_pkg: shared types, weights and widths for the pixel color adjust filter
// no dependencies; imported by pixel_color_adjust_filter
`timescale 1ns / 1ps

package pca_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEPIA_EN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_EN  = 3'd5;

  // stream payload
  localparam int unsigned PIX_W = 32;

  // contrast factor divider: quotient bits, remainder and divisor widths
  localparam int unsigned DIV_BITS = 18;
  localparam int unsigned REM_W    = 35;
  localparam int unsigned DEN_W    = 17;

  // weighted sums: 16-bit weight times 8-bit channel
  localparam int unsigned PROD_W = 24;
  localparam int unsigned SUM_W  = 26;

  // contrast product: signed 19-bit factor times signed 10-bit delta
  localparam int unsigned CPROD_W = 29;

  // q16 luma weights, red green blue
  localparam logic [15:0] GRAY_W [3] = '{16'd19595, 16'd38470, 16'd7471};

  // q16 sepia matrix, one row per output channel
  localparam logic [15:0] SEPIA_W [3][3] = '{
    '{16'd25756, 16'd50397, 16'd12386},
    '{16'd22872, 16'd44958, 16'd11010},
    '{16'd17826, 16'd34996, 16'd8585}
  };

  // color channels in order red, green, blue
  typedef struct packed {
    logic [7:0]      alpha;
    logic [2:0][7:0] rgb;
  } pix_t;

  // per-item step enables, snapshot of the registers at accept time
  typedef struct packed {
    logic con_en;
    logic gray_en;
    logic sep_en;
    logic inv_en;
  } ctl_t;

endpackage

// ===== design/pixel_color_adjust_filter.sv =====
// pixel_color_adjust_filter: pipelined argb8888 color adjustment
// depends on pca_pkg
`timescale 1ns / 1ps

// pipe: entry register, divider stages, then contrast, clamp, luma, grayscale, sepia and output registers
// throughput: one item per cycle; an item may enter every cycle while the output is taken
// the depth comes from the 18-stage restoring divider that forms the contrast factor
//   per item, one quotient bit per stage, so a register write applies from the next item
// reset: all valid bits and configuration registers clear, so the block passes pixels
//   unchanged until the filter is enabled

module pixel_color_adjust_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [pca_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [pca_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pca_pkg::PIX_W-1:0]      s_axis_tdata,  // alpha_in, red_in, green_in, blue_in
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pca_pkg::PIX_W-1:0]      m_axis_tdata   // alpha_out, red_out, green_out, blue_out
);

  import pca_pkg::*;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic              filter_en_q;
  logic signed [7:0] bright_q;
  logic signed [7:0] contrast_q;
  logic              gray_en_q;
  logic              sep_en_q;
  logic              inv_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= 1'b0;
      bright_q    <= '0;
      contrast_q  <= '0;
      gray_en_q   <= 1'b0;
      sep_en_q    <= 1'b0;
      inv_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FILTER_EN:  filter_en_q <= cfg_data_i[0];
        REG_BRIGHTNESS: bright_q    <= $signed(cfg_data_i);
        REG_CONTRAST:   contrast_q  <= $signed(cfg_data_i);
        REG_GRAY_EN:    gray_en_q   <= cfg_data_i[0];
        REG_SEPIA_EN:   sep_en_q    <= cfg_data_i[0];
        REG_INVERT_EN:  inv_en_q    <= cfg_data_i[0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline advance: the whole pipe moves whenever the output register is free
  // ---------------------------------------------------------------------------
  logic adv;
  logic ov_q;

  assign adv           = !ov_q || m_axis_tready;
  assign s_axis_tready = adv;

  function automatic logic [7:0] add_clamp(input logic [7:0] v, input logic signed [7:0] off);
    logic signed [9:0] s;
    s = $signed({2'b00, v}) + 10'(off);
    if (s[9]) begin
      add_clamp = 8'h00;
    end else if (s[8]) begin
      add_clamp = 8'hff;
    end else begin
      add_clamp = s[7:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // entry stage: brightness, step enables, contrast numerator and divisor
  // ---------------------------------------------------------------------------
  pix_t              in_pix;
  pix_t              bri_pix;
  ctl_t              in_ctl;
  logic signed [7:0] bright_eff;
  logic signed [7:0] contrast_eff;
  logic        [8:0] c_plus;    // c + 255, 127..382
  logic        [8:0] c_minus;   // 259 - c, 132..387
  logic [DEN_W-1:0]  num_hi;
  logic [DEN_W-1:0]  den_in;
  logic signed [9:0] c_plus_s;
  logic signed [9:0] c_minus_s;

  assign in_pix.alpha  = s_axis_tdata[7:0];
  assign in_pix.rgb[0] = s_axis_tdata[15:8];
  assign in_pix.rgb[1] = s_axis_tdata[23:16];
  assign in_pix.rgb[2] = s_axis_tdata[31:24];

  always_comb begin
    // with filtering off every step is disabled, which passes the pixel unchanged
    bright_eff   = filter_en_q ? bright_q : 8'sd0;
    contrast_eff = filter_en_q ? contrast_q : 8'sd0;

    in_ctl.con_en  = filter_en_q && (contrast_q != 8'sd0);
    in_ctl.gray_en = filter_en_q && gray_en_q;
    in_ctl.sep_en  = filter_en_q && sep_en_q;
    in_ctl.inv_en  = filter_en_q && inv_en_q;

    bri_pix.alpha = in_pix.alpha;
    for (int k = 0; k < 3; k++) begin
      bri_pix.rgb[k] = add_clamp(in_pix.rgb[k], bright_eff);
    end

    c_plus_s  = 10'(contrast_eff) + 10'sd255;
    c_minus_s = 10'sd259 - 10'(contrast_eff);
    c_plus    = c_plus_s[8:0];
    c_minus   = c_minus_s[8:0];
    num_hi    = DEN_W'(c_plus) * DEN_W'(259);
    den_in    = DEN_W'(c_minus) * DEN_W'(255);
  end

  // ---------------------------------------------------------------------------
  // contrast factor divider: element 0 is the entry register, each later
  // element resolves one quotient bit, most significant first
  // ---------------------------------------------------------------------------
  logic                dv_q   [0:DIV_BITS];
  pix_t                dpix_q [0:DIV_BITS];
  ctl_t                dctl_q [0:DIV_BITS];
  logic [REM_W-1:0]    drem_q [0:DIV_BITS];
  logic [DEN_W-1:0]    dden_q [0:DIV_BITS];
  logic [DIV_BITS-1:0] dquo_q [0:DIV_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dpix_q[0] <= bri_pix;
      dctl_q[0] <= in_ctl;
      drem_q[0] <= REM_W'({num_hi, 16'h0000});
      dden_q[0] <= den_in;
      dquo_q[0] <= '0;
    end
  end

  for (genvar i = 1; i <= DIV_BITS; i++) begin : g_div
    localparam int unsigned Sh = DIV_BITS - i;
    logic [REM_W-1:0] trial;

    assign trial = REM_W'(dden_q[i-1]) << Sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i] <= 1'b0;
      end else if (adv) begin
        dv_q[i] <= dv_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dpix_q[i] <= dpix_q[i-1];
        dctl_q[i] <= dctl_q[i-1];
        dden_q[i] <= dden_q[i-1];
        if (drem_q[i-1] >= trial) begin
          drem_q[i] <= drem_q[i-1] - trial;
          dquo_q[i] <= dquo_q[i-1] | (DIV_BITS'(1) << Sh);
        end else begin
          drem_q[i] <= drem_q[i-1];
          dquo_q[i] <= dquo_q[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // contrast products: factor * (v - 128) + 128 in q16
  // ---------------------------------------------------------------------------
  logic                      cv_q;
  pix_t                      cpix_q;
  ctl_t                      cctl_q;
  logic signed [CPROD_W-1:0] ct_q [3];
  logic signed [CPROD_W-1:0] ct_d [3];
  logic signed [DIV_BITS:0]  fac_s;
  logic signed [9:0]         delta [3];

  always_comb begin
    fac_s = $signed({1'b0, dquo_q[DIV_BITS]});
    for (int k = 0; k < 3; k++) begin
      delta[k] = $signed({2'b00, dpix_q[DIV_BITS].rgb[k]}) - 10'sd128;
      ct_d[k]  = fac_s * delta[k] + CPROD_W'(32'sd8388608);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= 1'b0;
    end else if (adv) begin
      cv_q <= dv_q[DIV_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cpix_q <= dpix_q[DIV_BITS];
      cctl_q <= dctl_q[DIV_BITS];
      ct_q   <= ct_d;
    end
  end

  // ---------------------------------------------------------------------------
  // contrast clamp: negative sums give 0, large ones 255
  // ---------------------------------------------------------------------------
  logic xv_q;
  pix_t xpix_q;
  pix_t xpix_d;
  ctl_t xctl_q;

  always_comb begin
    xpix_d = cpix_q;
    if (cctl_q.con_en) begin
      for (int k = 0; k < 3; k++) begin
        if (ct_q[k][CPROD_W-1]) begin
          xpix_d.rgb[k] = 8'h00;
        end else if (|ct_q[k][CPROD_W-2:24]) begin
          xpix_d.rgb[k] = 8'hff;
        end else begin
          xpix_d.rgb[k] = ct_q[k][23:16];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xv_q <= 1'b0;
    end else if (adv) begin
      xv_q <= cv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xpix_q <= xpix_d;
      xctl_q <= cctl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // luma products
  // ---------------------------------------------------------------------------
  logic              gv_q;
  pix_t              gpix_q;
  ctl_t              gctl_q;
  logic [PROD_W-1:0] gp_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gv_q <= 1'b0;
    end else if (adv) begin
      gv_q <= xv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gpix_q <= xpix_q;
      gctl_q <= xctl_q;
      for (int k = 0; k < 3; k++) begin
        gp_q[k] <= PROD_W'(xpix_q.rgb[k]) * PROD_W'(GRAY_W[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // luma sum and grayscale select
  // ---------------------------------------------------------------------------
  logic             yv_q;
  pix_t             ypix_q;
  pix_t             ypix_d;
  ctl_t             yctl_q;
  logic [SUM_W-1:0] gsum;
  logic [7:0]       luma;

  always_comb begin
    gsum   = SUM_W'(gp_q[0]) + SUM_W'(gp_q[1]) + SUM_W'(gp_q[2]);
    luma   = (|gsum[SUM_W-1:24]) ? 8'hff : gsum[23:16];
    ypix_d = gpix_q;
    if (gctl_q.gray_en) begin
      for (int k = 0; k < 3; k++) begin
        ypix_d.rgb[k] = luma;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yv_q <= 1'b0;
    end else if (adv) begin
      yv_q <= gv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ypix_q <= ypix_d;
      yctl_q <= gctl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // sepia products, one row of three per output channel
  // ---------------------------------------------------------------------------
  logic              sv_q;
  pix_t              spix_q;
  ctl_t              sctl_q;
  logic [PROD_W-1:0] sp_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else if (adv) begin
      sv_q <= yv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      spix_q <= ypix_q;
      sctl_q <= yctl_q;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          sp_q[j][k] <= PROD_W'(ypix_q.rgb[k]) * PROD_W'(SEPIA_W[j][k]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sepia sums with clamp, invert, output register
  // ---------------------------------------------------------------------------
  pix_t             opix_q;
  pix_t             opix_d;
  logic [SUM_W-1:0] ssum [3];

  always_comb begin
    opix_d = spix_q;
    for (int j = 0; j < 3; j++) begin
      ssum[j] = SUM_W'(sp_q[j][0]) + SUM_W'(sp_q[j][1]) + SUM_W'(sp_q[j][2]);
      if (sctl_q.sep_en) begin
        opix_d.rgb[j] = (|ssum[j][SUM_W-1:24]) ? 8'hff : ssum[j][23:16];
      end
      if (sctl_q.inv_en) begin
        opix_d.rgb[j] = ~opix_d.rgb[j];  // 255 - v
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= sv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      opix_q <= opix_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {opix_q.rgb[2], opix_q.rgb[1], opix_q.rgb[0], opix_q.alpha};

`ifndef SYNTH
  // the divider leaves a remainder below the divisor, so the factor is the floor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[DIV_BITS] |-> (drem_q[DIV_BITS] < REM_W'(dden_q[DIV_BITS])))
    else $error("contrast divider remainder not below divisor");

  // any legal contrast setting gives a nonzero factor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q[DIV_BITS] && dctl_q[DIV_BITS].con_en) |-> (dquo_q[DIV_BITS] != '0))
    else $error("contrast factor is zero");

  // after the grayscale step all three channels match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (yv_q && yctl_q.gray_en) |->
      ((ypix_q.rgb[0] == ypix_q.rgb[1]) && (ypix_q.rgb[1] == ypix_q.rgb[2])))
    else $error("grayscale channels differ");

  // a stalled output holds back the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // a stall freezes the last divider stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(dv_q[DIV_BITS]))
    else $error("pipeline moved during stall");
`endif

endmodule
